// ===== rtl/elliptic_kepler_solver_assert.svh =====
// Assertion macros used by the solver top level.
`ifndef ELLIPTIC_KEPLER_SOLVER_ASSERT_SVH
`define ELLIPTIC_KEPLER_SOLVER_ASSERT_SVH

// Same-cycle implication, reset masked.
`define EKEP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masked.
`define EKEP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ekep_pkg.sv =====
// Package: payload types, status codes, register indexes and constants.
`timescale 1ns / 1ps
package ekep_pkg;

    typedef struct packed {
        logic signed [31:0] mean_anomaly;
        logic        [31:0] eccentricity;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_INVALID_ECC = 2'd1,
        ST_FLAT_DERIV  = 2'd2,
        ST_NO_CONVERGE = 2'd3
    } t_status;

    typedef struct packed {
        logic signed [31:0] eccentric_anomaly;
        logic        [5:0]  iterations_used;
        t_status            status;
    } t_result;

    typedef enum logic [1:0] {
        REG_MAX_ITER  = 2'd0,
        REG_TOLERANCE = 2'd1,
        REG_DERIV_FLR = 2'd2
    } t_reg_index;

    localparam int CORDIC_STEPS = 30;
    localparam int XY_W = 34;
    localparam int Z_W = 35;
    localparam int DIV_W = 62;
    localparam int DVS_W = 34;

    localparam logic [5:0]  MAX_ITER_RST = 6'd20;
    localparam logic [15:0] TOL_RST = 16'd4;
    localparam logic [15:0] FLOOR_RST = 16'd1;

    localparam logic signed [33:0] PI_Q29 = 34'sd1686629713;
    localparam logic signed [34:0] PI_Q30 = 35'sd3373259426;
    localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q29 = 34'sd536870912;
    localparam logic [31:0] ECC_SWITCH = 32'd1717986919;

    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:  v = 30'd843314857;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043837;
            5'd3:  v = 30'd133525159;
            5'd4:  v = 30'd67021687;
            5'd5:  v = 30'd33543516;
            5'd6:  v = 30'd16775851;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194283;
            5'd9:  v = 30'd2097149;
            default: v = 30'd1 << (5'd30 - idx);
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/ekep_cordic.sv =====
// Iterative rotation CORDIC: one micro-rotation per cycle, sin and cos in Q4.30.
`timescale 1ns / 1ps
module ekep_cordic (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [31:0]                i_angle,
    output logic                              o_done,
    output logic signed [ekep_pkg::XY_W-1:0]  o_cos,
    output logic signed [ekep_pkg::XY_W-1:0]  o_sin
);
    import ekep_pkg::*;

    logic                   r_run, n_run;
    logic                   r_done, n_done;
    logic [4:0]             r_idx, n_idx;
    logic                   r_neg, n_neg;
    logic signed [XY_W-1:0] r_x, n_x, r_y, n_y;
    logic signed [Z_W-1:0]  r_z, n_z;
    logic signed [Z_W-1:0]  z_in;
    logic signed [Z_W-1:0]  atan_ext;

    assign z_in = {{(Z_W-33){i_angle[31]}}, i_angle, 1'b0};
    assign atan_ext = $signed({{(Z_W-30){1'b0}}, atan_q30(r_idx)});

    always_comb begin
        n_run  = r_run;
        n_done = 1'b0;
        n_idx  = r_idx;
        n_neg  = r_neg;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        if (i_start) begin
            n_run = 1'b1;
            n_idx = '0;
            n_x   = CORDIC_GAIN_Q30;
            n_y   = '0;
            if (z_in > HALF_PI_Q30) begin
                n_z   = z_in - PI_Q30;
                n_neg = 1'b1;
            end else if (z_in < -HALF_PI_Q30) begin
                n_z   = z_in + PI_Q30;
                n_neg = 1'b1;
            end else begin
                n_z   = z_in;
                n_neg = 1'b0;
            end
        end else if (r_run) begin
            if (r_z >= 0) begin
                n_x = r_x - (r_y >>> r_idx);
                n_y = r_y + (r_x >>> r_idx);
                n_z = r_z - atan_ext;
            end else begin
                n_x = r_x + (r_y >>> r_idx);
                n_y = r_y - (r_x >>> r_idx);
                n_z = r_z + atan_ext;
            end
            n_idx = r_idx + 5'd1;
            if (r_idx == 5'(CORDIC_STEPS - 1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
        r_idx <= n_idx;
        r_neg <= n_neg;
        r_x   <= n_x;
        r_y   <= n_y;
        r_z   <= n_z;
    end

    assign o_done = r_done;
    assign o_cos  = r_neg ? -r_x : r_x;
    assign o_sin  = r_neg ? -r_y : r_y;

endmodule

// ===== rtl/ekep_div.sv =====
// Restoring unsigned divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module ekep_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ekep_pkg::DIV_W-1:0]   i_dividend,
    input  logic [ekep_pkg::DVS_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [ekep_pkg::DIV_W-1:0]   o_quot
);
    import ekep_pkg::*;

    logic             r_run, n_run;
    logic             r_done, n_done;
    logic [5:0]       r_cnt, n_cnt;
    logic [DVS_W:0]   r_rem, n_rem;
    logic [DIV_W-1:0] r_quo, n_quo;
    logic [DVS_W-1:0] r_dvs, n_dvs;
    logic [DVS_W:0]   trial;

    assign trial = {r_rem[DVS_W-1:0], r_quo[DIV_W-1]};

    always_comb begin
        n_run  = r_run;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_run = 1'b1;
            n_cnt = '0;
            n_rem = '0;
            n_quo = i_dividend;
            n_dvs = i_divisor;
        end else if (r_run) begin
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = trial - {1'b0, r_dvs};
                n_quo = {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                n_rem = trial;
                n_quo = {r_quo[DIV_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'(DIV_W - 1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ===== rtl/elliptic_kepler_solver.sv =====
// Top level: APB registers, Newton sequencer, shared multiplier, CORDIC and divider.
//
//   channel   direction  handshake                     payload
//   command   in         start & !busy                 i_cmd  (t_cmd)
//   result    out        o_done, one cycle, no stall   o_result (t_result)
//   config    in/out     psel & penable & pwrite       pwdata / prdata
//
// An invalid eccentricity answers from the hold state; otherwise the mean anomaly and
// start estimate are set, then each Newton step runs CORDIC, products and divider.
// busy stays high from acceptance and is low again in the cycle of o_done.
// Reset is synchronous and restores the register defaults.
`timescale 1ns / 1ps
`include "elliptic_kepler_solver_assert.svh"
module elliptic_kepler_solver #(
    parameter int ANGLE_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ekep_pkg::t_cmd    i_cmd,
    output logic              o_done,
    output ekep_pkg::t_result o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import ekep_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_MEAN = 11'b00000000010,
        S_INIT = 11'b00000000100,
        S_CST  = 11'b00000001000,
        S_CORD = 11'b00000010000,
        S_MULS = 11'b00000100000,
        S_MULC = 11'b00001000000,
        S_RES  = 11'b00010000000,
        S_DIV  = 11'b00100000000,
        S_UPD  = 11'b01000000000,
        S_HOLD = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    logic [5:0]  r_max_iter;
    logic [15:0] r_tol, r_floor;
    logic        cfg_wr;
    t_reg_index  cfg_idx;

    logic [31:0]        aligned, raw;
    logic signed [31:0] r_ang, n_ang;
    logic [31:0]        r_ecc, n_ecc;
    logic signed [31:0] r_mean, n_mean;
    logic signed [31:0] r_est, n_est;
    logic signed [31:0] r_es, n_es;
    logic [5:0]         r_step, n_step;
    logic               r_qneg, n_qneg;
    logic signed [63:0] r_prod;
    logic               r_done, n_done;
    t_result            r_res, n_res;

    logic signed [XY_W-1:0] c_cos, c_sin;
    logic                   c_done, c_start;
    logic                   d_done, d_start;
    logic [DIV_W-1:0]       d_quot;

    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;
    logic signed [63:0] mean_sum;
    logic signed [33:0] resid, deriv;
    logic [33:0]        resid_abs, deriv_abs;
    logic               flat;
    logic signed [63:0] corr, est_new;
    logic signed [31:0] est_sat;
    logic               conv;

    assign raw = i_cmd.mean_anomaly;
    generate
        if (ANGLE_WIDTH >= 32) begin : g_align_down
            assign aligned = raw >> (ANGLE_WIDTH - 32);
        end else begin : g_align_up
            assign aligned = {raw[ANGLE_WIDTH-1:0], {(32-ANGLE_WIDTH){1'b0}}};
        end
    endgenerate

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign cfg_idx = t_reg_index'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= MAX_ITER_RST;
            r_tol      <= TOL_RST;
            r_floor    <= FLOOR_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_MAX_ITER:  r_max_iter <= pwdata[5:0];
                REG_TOLERANCE: r_tol      <= pwdata[15:0];
                REG_DERIV_FLR: r_floor    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_MAX_ITER:  prdata = {26'd0, r_max_iter};
            REG_TOLERANCE: prdata = {16'd0, r_tol};
            REG_DERIV_FLR: prdata = {16'd0, r_floor};
            default:       prdata = '0;
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_MEAN:  begin mul_a = {{2{r_ang[31]}}, r_ang}; mul_b = PI_Q29; end
            S_MULS:  begin mul_a = {3'b000, r_ecc[30:0]};   mul_b = c_sin;  end
            default: begin mul_a = {3'b000, r_ecc[30:0]};   mul_b = c_cos;  end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p[63:0];
    end

    assign mean_sum  = r_prod + 64'sd1073741824;
    assign resid     = {{2{r_est[31]}}, r_est} - {{2{r_es[31]}}, r_es}
                       - {{2{r_mean[31]}}, r_mean};
    assign deriv     = ONE_Q29 - {{2{r_prod[63]}}, r_prod[63:32]};
    assign resid_abs = resid[33] ? -resid : resid;
    assign deriv_abs = deriv[33] ? -deriv : deriv;
    assign flat      = deriv_abs <= {18'd0, r_floor};
    assign corr      = r_qneg ? -$signed({2'b00, d_quot}) : $signed({2'b00, d_quot});
    assign est_new   = {{32{r_est[31]}}, r_est} - corr;
    assign conv      = d_quot <= {{(DIV_W-16){1'b0}}, r_tol};

    always_comb begin
        if (est_new > 64'sd2147483647) begin
            est_sat = 32'sh7FFFFFFF;
        end else if (est_new < -64'sd2147483648) begin
            est_sat = 32'sh80000000;
        end else begin
            est_sat = est_new[31:0];
        end
    end

    assign c_start = (r_state == S_CST);
    assign d_start = (r_state == S_RES) && !flat;

    always_comb begin
        n_state = r_state;
        n_ang   = r_ang;
        n_ecc   = r_ecc;
        n_mean  = r_mean;
        n_est   = r_est;
        n_es    = r_es;
        n_step  = r_step;
        n_qneg  = r_qneg;
        n_done  = 1'b0;
        n_res   = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_ang = aligned;
                    n_ecc = i_cmd.eccentricity;
                    if (i_cmd.eccentricity[31]) begin
                        n_res   = '{eccentric_anomaly: '0, iterations_used: '0,
                                    status: ST_INVALID_ECC};
                        n_state = S_HOLD;
                    end else begin
                        n_state = S_MEAN;
                    end
                end
            end
            S_MEAN: n_state = S_INIT;
            S_INIT: begin
                n_mean = mean_sum[62:31];
                if (r_ecc < ECC_SWITCH) begin
                    n_est = mean_sum[62:31];
                end else begin
                    n_est = r_ang[31] ? -PI_Q29[31:0] : PI_Q29[31:0];
                end
                n_step = 6'd1;
                if (r_max_iter == '0) begin
                    n_res   = '{eccentric_anomaly: '0, iterations_used: '0,
                                status: ST_NO_CONVERGE};
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_CST;
                end
            end
            S_CST:  n_state = S_CORD;
            S_CORD: if (c_done) n_state = S_MULS;
            S_MULS: n_state = S_MULC;
            S_MULC: begin
                n_es    = r_prod[63:32];
                n_state = S_RES;
            end
            S_RES: begin
                n_qneg = resid[33] ^ deriv[33];
                if (flat) begin
                    n_res   = '{eccentric_anomaly: '0, iterations_used: r_step,
                                status: ST_FLAT_DERIV};
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: if (d_done) n_state = S_UPD;
            S_UPD: begin
                n_est = est_sat;
                if (conv) begin
                    n_res   = '{eccentric_anomaly: est_sat, iterations_used: r_step,
                                status: ST_OK};
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (r_step == r_max_iter) begin
                    n_res   = '{eccentric_anomaly: '0, iterations_used: r_max_iter,
                                status: ST_NO_CONVERGE};
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_step  = r_step + 6'd1;
                    n_state = S_CST;
                end
            end
            S_HOLD: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_est   <= '0;
            r_step  <= '0;
            r_ang   <= '0;
            r_ecc   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_est   <= n_est;
            r_step  <= n_step;
            r_ang   <= n_ang;
            r_ecc   <= n_ecc;
        end
        r_mean <= n_mean;
        r_es   <= n_es;
        r_qneg <= n_qneg;
        r_res  <= n_res;
    end

    ekep_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_start),
        .i_angle (r_est),
        .o_done  (c_done),
        .o_cos   (c_cos),
        .o_sin   (c_sin)
    );

    ekep_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (d_start),
        .i_dividend ({resid_abs[32:0], 29'd0}),
        .i_divisor  (deriv_abs),
        .o_done     (d_done),
        .o_quot     (d_quot)
    );

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

    `EKEP_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, o_done, !busy, "beat while busy")
    `EKEP_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, o_done && o_result.status != ST_OK,
        o_result.eccentric_anomaly == '0, "nonzero anomaly on failure")
    `EKEP_ASSERT_NOW(a_inv_iter, i_clk, i_rst_n, o_done && o_result.status == ST_INVALID_ECC,
        o_result.iterations_used == '0, "steps on invalid eccentricity")
    `EKEP_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy, "start not taken")

endmodule
